/* src/bloom_filter_five_hash_pair_key_unit_defines.svh */
// assertion macros shared by the bloom filter unit
`ifndef BLOOM_FILTER_FIVE_HASH_PAIR_KEY_UNIT_DEFINES_SVH
`define BLOOM_FILTER_FIVE_HASH_PAIR_KEY_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk and disabled in reset
`define BFK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk and disabled in reset
`define BFK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/bfk_pkg.sv */
// shared constants, types and structs of the bloom filter unit
package bfk_pkg;

  localparam int INDEX_BITS   = 16;
  localparam int FILTER_COUNT = 3;
  localparam int SEL_W        = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
  localparam int ADDR_W       = SEL_W + INDEX_BITS;
  localparam longint unsigned DEPTH = longint'(FILTER_COUNT) << INDEX_BITS;
  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(DEPTH - 1);

  localparam int HASH_COUNT = 5;
  localparam int STEP_W     = $clog2(2 * HASH_COUNT);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * HASH_COUNT - 1);

  localparam logic [31:0] LOW31     = 32'h7FFF_FFFF;
  localparam logic [31:0] BKDR_SEED = 32'd131;
  localparam logic [31:0] DJB_INIT  = 32'd5381;
  localparam logic [31:0] DJB_MUL   = 32'd33;
  localparam logic [31:0] JS_INIT   = 32'd1315423911;
  localparam logic [31:0] RS_A0     = 32'd63689;
  localparam logic [31:0] RS_B      = 32'd378551;
  localparam logic [31:0] RS_A1     = 32'(64'(RS_A0) * 64'(RS_B));

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    HASH_BKDR,
    HASH_AP,
    HASH_DJB,
    HASH_JS,
    HASH_RS
  } hash_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_HASH,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic       load;
    hash_kind_t kind;
    logic       round;
  } hash_ctl_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic              wdata;
    logic [ADDR_W-1:0] addr;
  } mem_req_t;

endpackage

/* src/bfk_hash_unit.sv */
// shared hash round unit: one round of one of the five string hashes per cycle while load is high
module bfk_hash_unit (
  input  logic                             clk,
  input  bfk_pkg::hash_ctl_t               ctl,
  input  logic [31:0]                      key_first,
  input  logic [31:0]                      key_second,
  output logic [bfk_pkg::INDEX_BITS-1:0]   index
);

  logic [31:0] h;
  logic [31:0] h_next;
  logic [31:0] h_cur;
  logic [31:0] w;
  logic [31:0] mul_b;
  logic [31:0] product;
  logic [31:0] h_masked;

  always_comb begin
    w = ctl.round ? key_second : key_first;

    // round zero starts from the seed of the selected hash
    if (ctl.round) begin
      h_cur = h;
    end else begin
      case (ctl.kind)
        bfk_pkg::HASH_DJB: h_cur = bfk_pkg::DJB_INIT;
        bfk_pkg::HASH_JS:  h_cur = bfk_pkg::JS_INIT;
        default:           h_cur = '0;
      endcase
    end

    case (ctl.kind)
      bfk_pkg::HASH_BKDR: mul_b = bfk_pkg::BKDR_SEED;
      bfk_pkg::HASH_DJB:  mul_b = bfk_pkg::DJB_MUL;
      bfk_pkg::HASH_RS:   mul_b = ctl.round ? bfk_pkg::RS_A1 : bfk_pkg::RS_A0;
      default:            mul_b = '0;
    endcase

    // the one shared multiplier, wrapping at 32 bits
    product = h_cur * mul_b;

    case (ctl.kind)
      bfk_pkg::HASH_BKDR,
      bfk_pkg::HASH_DJB,
      bfk_pkg::HASH_RS: h_next = product + w;
      bfk_pkg::HASH_AP: begin
        if (ctl.round) begin
          h_next = h_cur ^ ~((h_cur << 11) ^ w ^ (h_cur >> 5));
        end else begin
          h_next = h_cur ^ ((h_cur << 7) ^ w ^ (h_cur >> 3));
        end
      end
      bfk_pkg::HASH_JS: h_next = h_cur ^ ((h_cur << 5) + w + (h_cur >> 2));
      default:          h_next = h_cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      h <= h_next;
    end
  end

  assign h_masked = h & bfk_pkg::LOW31;
  assign index    = h_masked[bfk_pkg::INDEX_BITS-1:0];

endmodule

/* src/bfk_bit_store.sv */
// single-port one-bit cell store of all filters, registered read
module bfk_bit_store (
  input  logic              clk,
  input  bfk_pkg::mem_req_t req,
  output logic              rdata
);

  logic cells [bfk_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        cells[req.addr] <= req.wdata;
      end
      rdata <= cells[req.addr];
    end
  end

endmodule

/* src/bloom_filter_five_hash_pair_key_unit.sv */
// top level of the three-filter bloom filter unit with five key hashes
//
// A transaction is taken when start is high and busy is low. It carries a
// command (insert or query), a filter number and a two-word key. Five string
// hashes are worked out one round per cycle on a single shared hash unit
// (two rounds per hash), and each finished cell index is set or tested in
// the single-port bit store the cycle after. The result stands on hit when
// done is high, and done is high for a single cycle; the receiver cannot
// stall it, so it must be taken in that cycle. An insert, or any transaction
// on a filter number past the last filter, reports done once its last cell
// index has been handled in the store; a query of a valid filter reports
// done later, after the last read has come back. busy falls in the done
// cycle, so the next transaction may be started alongside the result. hit
// is 0 for every insert and 1 for a query only when all five cells are set.
// A filter number at or above the filter count leaves the store untouched
// and gives hit 0. After reset the block clears the store one cell per
// cycle, FILTER_COUNT * 2^INDEX_BITS cells (196608 as built), with busy high.
module bloom_filter_five_hash_pair_key_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [1:0]  filter_select,
  input  logic [31:0] key_first,
  input  logic [31:0] key_second,
  output logic        done,
  output logic        hit
);

  `include "bloom_filter_five_hash_pair_key_unit_defines.svh"

  bfk_pkg::state_t state;
  bfk_pkg::state_t state_next;

  logic [bfk_pkg::STEP_W-1:0]     step;
  logic [bfk_pkg::ADDR_W-1:0]     clear_addr;
  logic                           cmd_r;
  logic [1:0]                     sel_r;
  logic [31:0]                    key1_r;
  logic [31:0]                    key2_r;
  logic                           inrange;
  logic                           idx_valid;
  logic                           rd_valid;
  logic                           hit_acc;
  logic                           accept;
  logic                           finish;
  logic                           sel_ok;
  logic                           rdata;
  logic [bfk_pkg::INDEX_BITS-1:0] index;
  bfk_pkg::hash_ctl_t             hash_ctl;
  bfk_pkg::mem_req_t              mem_req;

  // shared hash round unit
  bfk_hash_unit u_hash (
    .clk        (clk),
    .ctl        (hash_ctl),
    .key_first  (key1_r),
    .key_second (key2_r),
    .index      (index)
  );

  // cell store of all filters
  bfk_bit_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign accept = start && !busy;
  assign sel_ok = 32'(filter_select) < 32'(bfk_pkg::FILTER_COUNT);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bfk_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = bfk_pkg::ST_HASH;
        end
      end
      bfk_pkg::ST_CLEAR: begin
        if (clear_addr == bfk_pkg::CLEAR_LAST) begin
          state_next = bfk_pkg::ST_IDLE;
        end
      end
      bfk_pkg::ST_HASH: begin
        if (step == bfk_pkg::STEP_LAST) begin
          state_next = bfk_pkg::ST_DRAIN;
        end
      end
      bfk_pkg::ST_DRAIN: begin
        if (finish) begin
          state_next = bfk_pkg::ST_IDLE;
        end
      end
      default: state_next = bfk_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy           = (state != bfk_pkg::ST_IDLE);
    finish         = (state == bfk_pkg::ST_DRAIN) && !idx_valid && !rd_valid;

    // step counts hash number in its upper bits and round in bit zero
    hash_ctl.load  = (state == bfk_pkg::ST_HASH);
    hash_ctl.kind  = bfk_pkg::hash_kind_t'(step[bfk_pkg::STEP_W-1:1]);
    hash_ctl.round = step[0];

    mem_req.en     = 1'b0;
    mem_req.we     = 1'b0;
    mem_req.wdata  = 1'b0;
    mem_req.addr   = clear_addr;
    case (state)
      bfk_pkg::ST_CLEAR: begin
        mem_req.en = 1'b1;
        mem_req.we = 1'b1;
      end
      bfk_pkg::ST_HASH,
      bfk_pkg::ST_DRAIN: begin
        // a finished index is touched while the next hash runs
        mem_req.en    = idx_valid && inrange;
        mem_req.we    = (cmd_r == bfk_pkg::CMD_INSERT);
        mem_req.wdata = 1'b1;
        mem_req.addr  = (bfk_pkg::ADDR_W'(sel_r) << bfk_pkg::INDEX_BITS)
                        | bfk_pkg::ADDR_W'(index);
      end
      default: begin
        mem_req.en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bfk_pkg::ST_CLEAR;
      clear_addr <= '0;
      step       <= '0;
      idx_valid  <= 1'b0;
      rd_valid   <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      idx_valid  <= (state == bfk_pkg::ST_HASH) && step[0];
      rd_valid   <= idx_valid && inrange && (cmd_r == bfk_pkg::CMD_QUERY);
      done       <= finish;
      if (state == bfk_pkg::ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (accept) begin
        step <= '0;
      end else if (state == bfk_pkg::ST_HASH) begin
        step <= step + 1'b1;
      end
    end
  end

  // transaction payload and hit accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= command;
      sel_r   <= filter_select;
      key1_r  <= key_first;
      key2_r  <= key_second;
      inrange <= sel_ok;
      hit_acc <= sel_ok && (command == bfk_pkg::CMD_QUERY);
    end else if (rd_valid) begin
      hit_acc <= hit_acc & rdata;
    end
    if (finish) begin
      hit <= hit_acc;
    end
  end

  `BFK_ASSERT_NOW(a_done_after_drain, done, $past(state) == bfk_pkg::ST_DRAIN, "done without drain")
  `BFK_ASSERT_NOW(a_no_write_on_query, mem_req.en && mem_req.we && (state != bfk_pkg::ST_CLEAR), cmd_r == bfk_pkg::CMD_INSERT, "store written during a query")
  `BFK_ASSERT_NEXT(a_busy_after_accept, accept, busy && (state == bfk_pkg::ST_HASH), "accept did not start hashing")
  `BFK_ASSERT_NOW(a_read_follows_index, rd_valid, $past(idx_valid) && (cmd_r == bfk_pkg::CMD_QUERY), "read data without a lookup")

endmodule

/* tb/sv/tb_bloom_filter_five_hash_pair_key_unit.sv */
// self-checking testbench of the three-filter bloom filter unit with five key hashes

// keeps a copy of the cell store and the queue of hit values still to come
class bloom_scoreboard;
  typedef logic [bfk_pkg::HASH_COUNT-1:0][bfk_pkg::INDEX_BITS-1:0] index_set_t;

  localparam logic [31:0] BKDR_MUL  = 32'd131;
  localparam logic [31:0] DJB_START = 32'd5381;
  localparam logic [31:0] JS_START  = 32'd1315423911;
  localparam logic [31:0] RS_A_INIT = 32'd63689;
  localparam logic [31:0] RS_A_STEP = 32'd378551;
  localparam logic [31:0] HASH_MASK = 32'h7FFF_FFFF;

  bit   set_cells[int unsigned];
  logic expected_hits[$];
  int   mismatch_count;

  function new();
    mismatch_count = 0;
  endfunction

  // 31-bit mask, then the low index bits
  function logic [bfk_pkg::INDEX_BITS-1:0] to_index(logic [31:0] h);
    logic [31:0] m;
    m = h & HASH_MASK;
    return m[bfk_pkg::INDEX_BITS-1:0];
  endfunction

  function index_set_t cell_indexes(logic [31:0] w0, logic [31:0] w1);
    index_set_t  idx;
    logic [31:0] h;
    logic [31:0] a;
    h = '0;
    h = h * BKDR_MUL + w0;
    h = h * BKDR_MUL + w1;
    idx[bfk_pkg::HASH_BKDR] = to_index(h);
    h = '0;
    h = h ^ ((h << 7) ^ w0 ^ (h >> 3));
    h = h ^ ~((h << 11) ^ w1 ^ (h >> 5));
    idx[bfk_pkg::HASH_AP] = to_index(h);
    h = DJB_START;
    h = h + (h << 5) + w0;
    h = h + (h << 5) + w1;
    idx[bfk_pkg::HASH_DJB] = to_index(h);
    h = JS_START;
    h = h ^ ((h << 5) + w0 + (h >> 2));
    h = h ^ ((h << 5) + w1 + (h >> 2));
    idx[bfk_pkg::HASH_JS] = to_index(h);
    h = '0;
    a = RS_A_INIT;
    h = h * a + w0;
    a = a * RS_A_STEP;
    h = h * a + w1;
    idx[bfk_pkg::HASH_RS] = to_index(h);
    return idx;
  endfunction

  // accepted transaction: update the store and queue the hit it must give
  function void note_txn(logic cmd, logic [1:0] sel, logic [31:0] k0, logic [31:0] k1);
    index_set_t  idx;
    int unsigned addr;
    logic        hit_now;
    hit_now = 1'b0;
    if (sel < bfk_pkg::FILTER_COUNT) begin
      idx = cell_indexes(k0, k1);
      hit_now = (cmd == bfk_pkg::CMD_QUERY);
      for (int i = 0; i < bfk_pkg::HASH_COUNT; i++) begin
        addr = (int'(sel) << bfk_pkg::INDEX_BITS) + int'(idx[i]);
        if (cmd == bfk_pkg::CMD_INSERT)
          set_cells[addr] = 1'b1;
        else if (!set_cells.exists(addr))
          hit_now = 1'b0;
      end
    end
    expected_hits.push_back(hit_now);
  endfunction

  function void check_hit(logic got);
    logic want;
    if (expected_hits.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] result with no transaction outstanding: hit=%b", $time, got);
    end else begin
      want = expected_hits.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] hit mismatch: expected %b, got %b", $time, want, got);
      end
    end
  endfunction

  function int pending();
    return expected_hits.size();
  endfunction
endclass

module tb_bloom_filter_five_hash_pair_key_unit;

  // longest stretch with no handshake: the clearing pass after reset, with margin
  localparam int WATCHDOG_LIMIT = 600000;
  localparam int RANDOM_ITEMS   = 630;
  localparam int CALM_TAIL      = 100;  // last transactions go back to back
  localparam int DRAIN_CYCLES   = 30;

  typedef struct {
    logic [1:0]  sel;
    logic [31:0] k0;
    logic [31:0] k1;
  } stored_key_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        command;
  logic [1:0]  filter_select;
  logic [31:0] key_first;
  logic [31:0] key_second;
  logic        done;
  logic        hit;

  bloom_scoreboard sb;
  stored_key_t     inserted_keys[$];
  int              idle_cycles;

  bloom_filter_five_hash_pair_key_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .filter_select(filter_select),
    .key_first    (key_first),
    .key_second   (key_second),
    .done         (done),
    .hit          (hit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: sample at the rising edge, before the block updates its outputs
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy)
        sb.note_txn(command, filter_select, key_first, key_second);
      if (done)
        sb.check_hit(hit);
      // watchdog: any handshake restarts the count
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // present one transaction and hold it until the block takes it
  task automatic send_txn(input logic cmd, input logic [1:0] sel,
                          input logic [31:0] k0, input logic [31:0] k1);
    @(negedge clk);
    start         <= 1'b1;
    command       <= cmd;
    filter_select <= sel;
    key_first     <= k0;
    key_second    <= k1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start for a number of cycles
  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // key words lean toward the corners now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 255));
      3: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    stored_key_t ent;
    logic [1:0]  sel;
    logic [31:0] k0;
    logic [31:0] k1;
    int          pick;

    sb            = new();
    rst           = 1'b1;
    start         = 1'b0;
    command       = bfk_pkg::CMD_INSERT;
    filter_select = 2'd0;
    key_first     = 32'd0;
    key_second    = 32'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    // a zero first word makes the bkdr and rs hashes land on the same cell
    send_txn(bfk_pkg::CMD_QUERY,  2'd0, 32'h0000_0000, 32'h0000_0000);  // empty store
    send_txn(bfk_pkg::CMD_INSERT, 2'd0, 32'h0000_0000, 32'h0000_0000);
    send_txn(bfk_pkg::CMD_QUERY,  2'd0, 32'h0000_0000, 32'h0000_0000);
    send_txn(bfk_pkg::CMD_QUERY,  2'd1, 32'h0000_0000, 32'h0000_0000);  // other filter
    send_txn(bfk_pkg::CMD_INSERT, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_txn(bfk_pkg::CMD_QUERY,  2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_txn(bfk_pkg::CMD_QUERY,  2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_txn(bfk_pkg::CMD_INSERT, 2'd1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_txn(bfk_pkg::CMD_QUERY,  2'd1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_txn(bfk_pkg::CMD_QUERY,  2'd1, 32'h0000_0000, 32'hFFFF_FFFF);  // swapped words
    // filter number past the last filter: insert dropped, query misses
    send_txn(bfk_pkg::CMD_INSERT, 2'd3, 32'h1234_5678, 32'h9ABC_DEF0);
    send_txn(bfk_pkg::CMD_QUERY,  2'd3, 32'h1234_5678, 32'h9ABC_DEF0);
    send_txn(bfk_pkg::CMD_QUERY,  2'd0, 32'h1234_5678, 32'h9ABC_DEF0);
    send_txn(bfk_pkg::CMD_INSERT, 2'd0, 32'h8000_0000, 32'h0000_0001);
    send_txn(bfk_pkg::CMD_QUERY,  2'd0, 32'h8000_0000, 32'h0000_0001);
    send_txn(bfk_pkg::CMD_QUERY,  2'd0, 32'h0000_0001, 32'h8000_0000);
    send_txn(bfk_pkg::CMD_INSERT, 2'd2, 32'h0000_0000, 32'hDEAD_BEEF);
    send_txn(bfk_pkg::CMD_QUERY,  2'd2, 32'h0000_0000, 32'hDEAD_BEEF);
    send_txn(bfk_pkg::CMD_QUERY,  2'd3, 32'h0000_0000, 32'h0000_0000);

    // random part: mostly inserts and queries of keys already inserted
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 || inserted_keys.size() == 0) begin
        ent.sel = 2'($urandom_range(0, bfk_pkg::FILTER_COUNT - 1));
        ent.k0  = pick_word();
        ent.k1  = pick_word();
        inserted_keys.push_back(ent);
        send_txn(bfk_pkg::CMD_INSERT, ent.sel, ent.k0, ent.k1);
      end else if (pick < 65) begin
        // known key on its own filter
        ent = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        send_txn(bfk_pkg::CMD_QUERY, ent.sel, ent.k0, ent.k1);
      end else if (pick < 72) begin
        // known key on a different filter
        ent = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        sel = 2'((int'(ent.sel) + $urandom_range(1, bfk_pkg::FILTER_COUNT - 1))
                 % bfk_pkg::FILTER_COUNT);
        send_txn(bfk_pkg::CMD_QUERY, sel, ent.k0, ent.k1);
      end else if (pick < 80) begin
        // fresh key, almost always a miss
        send_txn(bfk_pkg::CMD_QUERY, 2'($urandom_range(0, bfk_pkg::FILTER_COUNT - 1)),
                 pick_word(), pick_word());
      end else if (pick < 90) begin
        // noise over the whole field ranges
        k0 = $urandom;
        k1 = $urandom;
        send_txn(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), k0, k1);
      end else begin
        // out-of-range filter, sometimes with a key known elsewhere
        ent = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        send_txn(1'($urandom_range(0, 1)), 2'd3, ent.k0, ent.k1);
      end
      // random sender bursts of idle, none near the end
      if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
        idle_gap($urandom_range(1, 5));
    end

    @(negedge clk);
    start <= 1'b0;

    // drain outstanding results, then watch for stray ones
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/bfk_pkg.sv
src/bfk_hash_unit.sv
src/bfk_bit_store.sv
src/bloom_filter_five_hash_pair_key_unit.sv
tb/sv/tb_bloom_filter_five_hash_pair_key_unit.sv
